[rtl/core/bidirectional_flow_stats_update_defines.svh]
// Assertion macros shared by the flow statistics checker.
// No dependencies; the using scope must provide clk, rst_n and rec_valid.
`ifndef BIDIRECTIONAL_FLOW_STATS_UPDATE_DEFINES_SVH
`define BIDIRECTIONAL_FLOW_STATS_UPDATE_DEFINES_SVH

// Condition that must hold whenever a record beat is offered
`define BFSU_ASSERT_ON_REC(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (rec_valid) |-> (cond)) \
        else $error(msg);

// Consequent that must hold in the cycle after the antecedent
`define BFSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/bfsu_pkg.sv]
// Shared types, constants and helper functions for the flow statistics block.
// No dependencies; imported by bfsu_front, bfsu_queue, bfsu_back and the top module.
package bfsu_pkg;

    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam int          FLAG_FIN_BIT  = 0;
    localparam int          FLAG_SYN_BIT  = 1;
    localparam int          FLAG_RST_BIT  = 2;
    localparam logic [19:0] US_PER_SECOND = 20'd1000000;
    localparam logic [31:0] COUNT_MAX     = 32'hFFFF_FFFF;
    localparam logic [47:0] BYTES_MAX     = 48'hFFFF_FFFF_FFFF;

    // Decoupling queue between classifier and update engine
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        SLOT_A     = 2'd0,
        SLOT_B     = 2'd1,
        SLOT_OTHER = 2'd2
    } slot_t;

    typedef struct packed {
        logic [31:0] src_address;
        logic [31:0] dst_address;
        logic [15:0] source_port;
        logic [15:0] dest_port;
        logic [7:0]  protocol;
    } flow_key_t;

    // Per-packet class bits decided at the front
    typedef struct packed {
        logic truncated;
        logic syn_hit;
        logic fin_hit;
        logic rst_hit;
    } pkt_class_t;

    // First front stage: timestamp product not yet combined
    typedef struct packed {
        flow_key_t   key;
        logic [51:0] product;
        logic [19:0] usecs;
        logic [17:0] cap_length;
        logic [17:0] wire_length;
        pkt_class_t  cls;
    } front_stage_t;

    // Classified descriptor handed to the update engine
    typedef struct packed {
        flow_key_t   key;
        logic [51:0] time_us;
        logic [17:0] cap_length;
        logic [17:0] wire_length;
        pkt_class_t  cls;
    } pkt_desc_t;

    function automatic logic [31:0] sat_inc32(input logic [31:0] value, input logic en);
        logic [31:0] result;
        result = value;
        if (en && (value != COUNT_MAX))
        begin
            result = value + 32'd1;
        end
        return result;
    endfunction

    function automatic logic [47:0] sat_add48(input logic [47:0] acc, input logic [17:0] len);
        logic [48:0] sum;
        sum = {1'b0, acc} + {31'b0, len};
        return sum[48] ? BYTES_MAX : sum[47:0];
    endfunction

endpackage

[rtl/core/bidirectional_flow_stats_update.sv]
// Path: a packet beat passes two front stages (the timestamp multiply is staged), the
// queue and the record registers. Throughput: one packet beat per cycle while rec_stall
// is low; the record update (compare and add on 48- and 52-bit fields) is combinational.
// Reset: rst_n is asynchronous, active low; clears the record and both key valid bits.
// Built from bfsu_front, bfsu_queue and bfsu_back; uses bfsu_pkg.
module bidirectional_flow_stats_update (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pkt_valid,
    output logic        pkt_stall,
    input  logic [31:0] src_address,
    input  logic [31:0] dst_address,
    input  logic [15:0] source_port,
    input  logic [15:0] dest_port,
    input  logic [7:0]  protocol,
    input  logic [31:0] ts_seconds,
    input  logic [19:0] ts_microseconds,
    input  logic [17:0] cap_length,
    input  logic [17:0] wire_length,
    input  logic [7:0]  flag_byte,
    output logic        rec_valid,
    input  logic        rec_stall,
    output logic [1:0]  direction_slot,
    output logic [31:0] packet_total,
    output logic [47:0] byte_total,
    output logic [47:0] captured_byte_total,
    output logic [51:0] first_time_us,
    output logic [51:0] last_time_us,
    output logic [31:0] truncated_total,
    output logic [17:0] max_wire_length,
    output logic [17:0] max_capture_length,
    output logic [31:0] syn_total,
    output logic [31:0] fin_total,
    output logic [31:0] rst_total
);
    import bfsu_pkg::*;

    logic      push_valid;
    logic      push_ready;
    pkt_desc_t push_desc;
    logic      head_valid;
    logic      head_ready;
    pkt_desc_t head_desc;

    // Classifier and timestamp builder
    bfsu_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .pkt_valid       (pkt_valid),
        .pkt_stall       (pkt_stall),
        .src_address     (src_address),
        .dst_address     (dst_address),
        .source_port     (source_port),
        .dest_port       (dest_port),
        .protocol        (protocol),
        .ts_seconds      (ts_seconds),
        .ts_microseconds (ts_microseconds),
        .cap_length      (cap_length),
        .wire_length     (wire_length),
        .flag_byte       (flag_byte),
        .desc_valid      (push_valid),
        .desc            (push_desc),
        .desc_ready      (push_ready)
    );

    // Decoupling queue
    bfsu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_desc  (push_desc),
        .pop_valid  (head_valid),
        .pop_ready  (head_ready),
        .pop_desc   (head_desc)
    );

    // Record update engine
    bfsu_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .head_valid          (head_valid),
        .head_ready          (head_ready),
        .head_desc           (head_desc),
        .rec_valid           (rec_valid),
        .rec_stall           (rec_stall),
        .direction_slot      (direction_slot),
        .packet_total        (packet_total),
        .byte_total          (byte_total),
        .captured_byte_total (captured_byte_total),
        .first_time_us       (first_time_us),
        .last_time_us        (last_time_us),
        .truncated_total     (truncated_total),
        .max_wire_length     (max_wire_length),
        .max_capture_length  (max_capture_length),
        .syn_total           (syn_total),
        .fin_total           (fin_total),
        .rst_total           (rst_total)
    );

endmodule

[rtl/core/bfsu_front.sv]
// Front end: accepts packet beats, decodes flags and truncation, and builds
// the microsecond timestamp over two stages. Depends on bfsu_pkg.
module bfsu_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pkt_valid,
    output logic                pkt_stall,
    input  logic [31:0]         src_address,
    input  logic [31:0]         dst_address,
    input  logic [15:0]         source_port,
    input  logic [15:0]         dest_port,
    input  logic [7:0]          protocol,
    input  logic [31:0]         ts_seconds,
    input  logic [19:0]         ts_microseconds,
    input  logic [17:0]         cap_length,
    input  logic [17:0]         wire_length,
    input  logic [7:0]          flag_byte,
    output logic                desc_valid,
    output bfsu_pkg::pkt_desc_t desc,
    input  logic                desc_ready
);
    import bfsu_pkg::*;

    logic         s1_valid_reg;
    logic         s1_valid_next;
    front_stage_t s1_reg;
    front_stage_t s1_next;
    logic         s2_valid_reg;
    logic         s2_valid_next;
    pkt_desc_t    s2_reg;
    pkt_desc_t    s2_next;
    logic         s1_ready;
    logic         s2_ready;
    logic         is_tcp;

    // Elastic two-stage pipe
    assign s2_ready  = !s2_valid_reg || desc_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign pkt_stall = !s1_ready;

    assign s1_valid_next = s1_ready ? pkt_valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    // Stage 1: classify and multiply seconds up to microseconds
    assign is_tcp = (protocol == PROTO_TCP);

    always_comb
    begin
        s1_next.key.src_address = src_address;
        s1_next.key.dst_address = dst_address;
        s1_next.key.source_port = source_port;
        s1_next.key.dest_port   = dest_port;
        s1_next.key.protocol    = protocol;
        s1_next.product         = 52'(ts_seconds) * 52'(US_PER_SECOND);
        s1_next.usecs           = ts_microseconds;
        s1_next.cap_length      = cap_length;
        s1_next.wire_length     = wire_length;
        s1_next.cls.truncated   = (cap_length < wire_length);
        s1_next.cls.syn_hit     = is_tcp && flag_byte[FLAG_SYN_BIT];
        s1_next.cls.fin_hit     = is_tcp && flag_byte[FLAG_FIN_BIT];
        s1_next.cls.rst_hit     = is_tcp && flag_byte[FLAG_RST_BIT];
    end

    // Stage 2: add the microsecond part
    always_comb
    begin
        s2_next.key         = s1_reg.key;
        s2_next.time_us     = s1_reg.product + 52'(s1_reg.usecs);
        s2_next.cap_length  = s1_reg.cap_length;
        s2_next.wire_length = s1_reg.wire_length;
        s2_next.cls         = s1_reg.cls;
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // Stage payloads
    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_reg <= s1_next;
        end
        if (s2_ready)
        begin
            s2_reg <= s2_next;
        end
    end

    assign desc_valid = s2_valid_reg;
    assign desc       = s2_reg;

endmodule

[rtl/core/bfsu_queue.sv]
// Short FIFO that decouples the front end from the update engine.
// Depends on bfsu_pkg for the descriptor type and depth.
module bfsu_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  bfsu_pkg::pkt_desc_t push_desc,
    output logic                pop_valid,
    input  logic                pop_ready,
    output bfsu_pkg::pkt_desc_t pop_desc
);
    import bfsu_pkg::*;

    pkt_desc_t              entry_q [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_PTR_W:0]   count_reg;
    logic [QUEUE_PTR_W:0]   count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = (count_reg != (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_desc   = entry_q[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + QUEUE_PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + QUEUE_PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + (QUEUE_PTR_W + 1)'(1);
            2'b01:   count_next = count_reg - (QUEUE_PTR_W + 1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_q[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

[rtl/core/bfsu_back.sv]
// Update engine: while not stalled, applies one descriptor per cycle to the
// connection record, presented as the result beat. Depends on bfsu_pkg.
module bfsu_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    output logic                head_ready,
    input  bfsu_pkg::pkt_desc_t head_desc,
    output logic                rec_valid,
    input  logic                rec_stall,
    output logic [1:0]          direction_slot,
    output logic [31:0]         packet_total,
    output logic [47:0]         byte_total,
    output logic [47:0]         captured_byte_total,
    output logic [51:0]         first_time_us,
    output logic [51:0]         last_time_us,
    output logic [31:0]         truncated_total,
    output logic [17:0]         max_wire_length,
    output logic [17:0]         max_capture_length,
    output logic [31:0]         syn_total,
    output logic [31:0]         fin_total,
    output logic [31:0]         rst_total
);
    import bfsu_pkg::*;

    logic        rec_valid_reg, rec_valid_next;
    slot_t       slot_reg, slot_next;
    logic        dir_a_valid_reg, dir_a_valid_next;
    logic        dir_b_valid_reg, dir_b_valid_next;
    flow_key_t   dir_a_key_reg, dir_a_key_next;
    flow_key_t   dir_b_key_reg, dir_b_key_next;
    logic [31:0] pkt_count_reg, pkt_count_next;
    logic [47:0] wire_bytes_reg, wire_bytes_next;
    logic [47:0] cap_bytes_reg, cap_bytes_next;
    logic [51:0] earliest_reg, earliest_next;
    logic [51:0] latest_reg, latest_next;
    logic [31:0] trunc_count_reg, trunc_count_next;
    logic [17:0] max_wire_reg, max_wire_next;
    logic [17:0] max_cap_reg, max_cap_next;
    logic [31:0] syn_count_reg, syn_count_next;
    logic [31:0] fin_count_reg, fin_count_next;
    logic [31:0] rst_count_reg, rst_count_next;
    logic        take;
    logic        first_pkt;
    logic        a_hit;
    logic        b_hit;

    // Result register frees up when empty or being drained this cycle
    assign head_ready = !rec_valid_reg || !rec_stall;
    assign take       = head_valid && head_ready;

    assign first_pkt = (pkt_count_reg == '0);
    assign a_hit     = (dir_a_key_reg == head_desc.key);
    assign b_hit     = (dir_b_key_reg == head_desc.key);

    assign rec_valid_next = take || (rec_valid_reg && rec_stall);

    // Record update
    always_comb
    begin
        slot_next        = slot_reg;
        dir_a_valid_next = dir_a_valid_reg;
        dir_b_valid_next = dir_b_valid_reg;
        dir_a_key_next   = dir_a_key_reg;
        dir_b_key_next   = dir_b_key_reg;
        pkt_count_next   = pkt_count_reg;
        wire_bytes_next  = wire_bytes_reg;
        cap_bytes_next   = cap_bytes_reg;
        earliest_next    = earliest_reg;
        latest_next      = latest_reg;
        trunc_count_next = trunc_count_reg;
        max_wire_next    = max_wire_reg;
        max_cap_next     = max_cap_reg;
        syn_count_next   = syn_count_reg;
        fin_count_next   = fin_count_reg;
        rst_count_next   = rst_count_reg;
        if (take)
        begin
            pkt_count_next   = sat_inc32(pkt_count_reg, 1'b1);
            wire_bytes_next  = sat_add48(wire_bytes_reg, head_desc.wire_length);
            cap_bytes_next   = sat_add48(cap_bytes_reg, head_desc.cap_length);
            trunc_count_next = sat_inc32(trunc_count_reg, head_desc.cls.truncated);
            syn_count_next   = sat_inc32(syn_count_reg, head_desc.cls.syn_hit);
            fin_count_next   = sat_inc32(fin_count_reg, head_desc.cls.fin_hit);
            rst_count_next   = sat_inc32(rst_count_reg, head_desc.cls.rst_hit);

            // Time window: first packet sets both ends, later ones widen it
            if (first_pkt || (head_desc.time_us < earliest_reg))
            begin
                earliest_next = head_desc.time_us;
            end
            if (first_pkt || (head_desc.time_us > latest_reg))
            begin
                latest_next = head_desc.time_us;
            end

            if (head_desc.wire_length > max_wire_reg)
            begin
                max_wire_next = head_desc.wire_length;
            end
            if (head_desc.cap_length > max_cap_reg)
            begin
                max_cap_next = head_desc.cap_length;
            end

            // Direction lookup; first two distinct keys claim A then B
            if (!dir_a_valid_reg)
            begin
                dir_a_valid_next = 1'b1;
                dir_a_key_next   = head_desc.key;
                slot_next        = SLOT_A;
            end
            else if (a_hit)
            begin
                slot_next = SLOT_A;
            end
            else if (!dir_b_valid_reg)
            begin
                dir_b_valid_next = 1'b1;
                dir_b_key_next   = head_desc.key;
                slot_next        = SLOT_B;
            end
            else if (b_hit)
            begin
                slot_next = SLOT_B;
            end
            else
            begin
                slot_next = SLOT_OTHER;
            end
        end
    end

    // Control and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec_valid_reg   <= 1'b0;
            slot_reg        <= SLOT_A;
            dir_a_valid_reg <= 1'b0;
            dir_b_valid_reg <= 1'b0;
            pkt_count_reg   <= '0;
            wire_bytes_reg  <= '0;
            cap_bytes_reg   <= '0;
            earliest_reg    <= '0;
            latest_reg      <= '0;
            trunc_count_reg <= '0;
            max_wire_reg    <= '0;
            max_cap_reg     <= '0;
            syn_count_reg   <= '0;
            fin_count_reg   <= '0;
            rst_count_reg   <= '0;
        end
        else
        begin
            rec_valid_reg   <= rec_valid_next;
            slot_reg        <= slot_next;
            dir_a_valid_reg <= dir_a_valid_next;
            dir_b_valid_reg <= dir_b_valid_next;
            pkt_count_reg   <= pkt_count_next;
            wire_bytes_reg  <= wire_bytes_next;
            cap_bytes_reg   <= cap_bytes_next;
            earliest_reg    <= earliest_next;
            latest_reg      <= latest_next;
            trunc_count_reg <= trunc_count_next;
            max_wire_reg    <= max_wire_next;
            max_cap_reg     <= max_cap_next;
            syn_count_reg   <= syn_count_next;
            fin_count_reg   <= fin_count_next;
            rst_count_reg   <= rst_count_next;
        end
    end

    // Direction keys, guarded by their valid bits
    always_ff @(posedge clk)
    begin
        dir_a_key_reg <= dir_a_key_next;
        dir_b_key_reg <= dir_b_key_next;
    end

    // Record registers double as the result beat
    assign rec_valid           = rec_valid_reg;
    assign direction_slot      = slot_reg;
    assign packet_total        = pkt_count_reg;
    assign byte_total          = wire_bytes_reg;
    assign captured_byte_total = cap_bytes_reg;
    assign first_time_us       = earliest_reg;
    assign last_time_us        = latest_reg;
    assign truncated_total     = trunc_count_reg;
    assign max_wire_length     = max_wire_reg;
    assign max_capture_length  = max_cap_reg;
    assign syn_total           = syn_count_reg;
    assign fin_total           = fin_count_reg;
    assign rst_total           = rst_count_reg;

endmodule

[rtl/core/bfsu_checker.sv]
// Port-level checker for the flow statistics block, bound to the top level.
// Depends on bidirectional_flow_stats_update_defines.svh for the assertion macros.
`include "bidirectional_flow_stats_update_defines.svh"

module bfsu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        rec_valid,
    input logic        rec_stall,
    input logic [31:0] packet_total,
    input logic [47:0] byte_total,
    input logic [47:0] captured_byte_total,
    input logic [51:0] first_time_us,
    input logic [51:0] last_time_us,
    input logic [31:0] truncated_total,
    input logic [17:0] max_wire_length,
    input logic [17:0] max_capture_length,
    input logic [31:0] syn_total
);

    // Time window never inverts
    `BFSU_ASSERT_ON_REC(a_time_window, first_time_us <= last_time_us, "time window inverted")

    // Per-packet counts stay within the packet count
    `BFSU_ASSERT_ON_REC(a_counts_bounded, (truncated_total <= packet_total) && (syn_total <= packet_total), "count exceeds packet total")

    // Largest lengths are covered by the byte sums
    `BFSU_ASSERT_ON_REC(a_max_in_sum, (48'(max_wire_length) <= byte_total) && (48'(max_capture_length) <= captured_byte_total), "max length above byte sum")

    // A stalled result beat is not withdrawn
    `BFSU_ASSERT_NEXT(a_rec_held, rec_valid && rec_stall, rec_valid, "result beat dropped under stall")

endmodule

bind bidirectional_flow_stats_update bfsu_checker u_bfsu_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .rec_valid           (rec_valid),
    .rec_stall           (rec_stall),
    .packet_total        (packet_total),
    .byte_total          (byte_total),
    .captured_byte_total (captured_byte_total),
    .first_time_us       (first_time_us),
    .last_time_us        (last_time_us),
    .truncated_total     (truncated_total),
    .max_wire_length     (max_wire_length),
    .max_capture_length  (max_capture_length),
    .syn_total           (syn_total)
);

[tb/tb_bidirectional_flow_stats_update.sv]
// Self-checking testbench for bidirectional_flow_stats_update: packet beats in, one
// record beat out per packet, checked against a cycle-free connection record model.
// Depends on bfsu_pkg (key type, slot codes, limits) and the block's RTL only.
module tb_bidirectional_flow_stats_update;
    import bfsu_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        flow_key_t   key;
        logic [31:0] secs;
        logic [19:0] usecs;
        logic [17:0] cap_len;
        logic [17:0] wire_len;
        logic [7:0]  flags;
    } packet_beat_t;

    typedef struct packed {
        slot_t       slot;
        logic [31:0] packets;
        logic [47:0] bytes;
        logic [47:0] cap_bytes;
        logic [51:0] first_us;
        logic [51:0] last_us;
        logic [31:0] truncated;
        logic [17:0] wire_peak;
        logic [17:0] cap_peak;
        logic [31:0] syns;
        logic [31:0] fins;
        logic [31:0] rsts;
    } flow_record_t;

    // Connection record model plus the queue of records still owed by the block
    class flow_record_scoreboard;
        flow_key_t    key_a;
        flow_key_t    key_b;
        bit           have_a;
        bit           have_b;
        logic [31:0]  pkts;
        logic [31:0]  truncs;
        logic [31:0]  syns;
        logic [31:0]  fins;
        logic [31:0]  rsts;
        logic [47:0]  wire_sum;
        logic [47:0]  cap_sum;
        logic [51:0]  earliest;
        logic [51:0]  latest;
        logic [17:0]  wire_peak;
        logic [17:0]  cap_peak;
        flow_record_t owed_records[$];
        int           errors;
        int           checked;
        int           slot_hits[3];

        function new();
            key_a     = '0;
            key_b     = '0;
            have_a    = 1'b0;
            have_b    = 1'b0;
            pkts      = '0;
            truncs    = '0;
            syns      = '0;
            fins      = '0;
            rsts      = '0;
            wire_sum  = '0;
            cap_sum   = '0;
            earliest  = '0;
            latest    = '0;
            wire_peak = '0;
            cap_peak  = '0;
            errors    = 0;
            checked   = 0;
            slot_hits = '{0, 0, 0};
        endfunction

        // Counters stick at all ones
        function logic [31:0] bump_count(input logic [31:0] count, input logic hit);
            if (hit && count != COUNT_MAX)
                return count + 32'd1;
            return count;
        endfunction

        function logic [47:0] add_bytes(input logic [47:0] acc, input logic [17:0] len);
            if (BYTES_MAX - acc < {30'd0, len})
                return BYTES_MAX;
            return acc + {30'd0, len};
        endfunction

        // Accepted packet beat: update the record and queue what the block must show
        function void note_packet(input packet_beat_t p);
            flow_record_t want;
            logic [63:0]  stamp;
            logic         tcp;
            stamp = 64'(p.secs) * 64'(US_PER_SECOND) + 64'(p.usecs);
            tcp   = (p.key.protocol == PROTO_TCP);

            // first packet opens the time window, later ones only widen it
            if (pkts == 32'd0)
            begin
                earliest = stamp[51:0];
                latest   = stamp[51:0];
            end
            else
            begin
                if (stamp[51:0] < earliest)
                    earliest = stamp[51:0];
                if (stamp[51:0] > latest)
                    latest = stamp[51:0];
            end

            pkts     = bump_count(pkts, 1'b1);
            wire_sum = add_bytes(wire_sum, p.wire_len);
            cap_sum  = add_bytes(cap_sum, p.cap_len);
            truncs   = bump_count(truncs, p.cap_len < p.wire_len);
            if (p.wire_len > wire_peak)
                wire_peak = p.wire_len;
            if (p.cap_len > cap_peak)
                cap_peak = p.cap_len;

            // flag counts only for TCP
            syns = bump_count(syns, tcp && p.flags[FLAG_SYN_BIT]);
            fins = bump_count(fins, tcp && p.flags[FLAG_FIN_BIT]);
            rsts = bump_count(rsts, tcp && p.flags[FLAG_RST_BIT]);

            // A is the first key seen, B the second distinct one, anything else gets the other slot
            if (!have_a)
            begin
                have_a    = 1'b1;
                key_a     = p.key;
                want.slot = SLOT_A;
            end
            else if (p.key == key_a)
                want.slot = SLOT_A;
            else if (!have_b)
            begin
                have_b    = 1'b1;
                key_b     = p.key;
                want.slot = SLOT_B;
            end
            else if (p.key == key_b)
                want.slot = SLOT_B;
            else
                want.slot = SLOT_OTHER;

            want.packets   = pkts;
            want.bytes     = wire_sum;
            want.cap_bytes = cap_sum;
            want.first_us  = earliest;
            want.last_us   = latest;
            want.truncated = truncs;
            want.wire_peak = wire_peak;
            want.cap_peak  = cap_peak;
            want.syns      = syns;
            want.fins      = fins;
            want.rsts      = rsts;
            slot_hits[int'(want.slot)]++;
            owed_records.insert(owed_records.size(), want);
        endfunction

        // One line per mismatch, each one counted
        task report_mismatch(input string msg);
            errors++;
            $display("mismatch at record %0d: %s", checked, msg);
        endtask

        task check_field(input string name, input logic [63:0] got, input logic [63:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
        endtask

        task check_record(input flow_record_t got);
            flow_record_t want;
            if (owed_records.size() == 0)
            begin
                report_mismatch("record beat with no packet outstanding");
                return;
            end
            want = owed_records.pop_front();
            check_field("direction_slot", 64'(got.slot), 64'(want.slot));
            check_field("packet_total", 64'(got.packets), 64'(want.packets));
            check_field("byte_total", 64'(got.bytes), 64'(want.bytes));
            check_field("captured_byte_total", 64'(got.cap_bytes), 64'(want.cap_bytes));
            check_field("first_time_us", 64'(got.first_us), 64'(want.first_us));
            check_field("last_time_us", 64'(got.last_us), 64'(want.last_us));
            check_field("truncated_total", 64'(got.truncated), 64'(want.truncated));
            check_field("max_wire_length", 64'(got.wire_peak), 64'(want.wire_peak));
            check_field("max_capture_length", 64'(got.cap_peak), 64'(want.cap_peak));
            check_field("syn_total", 64'(got.syns), 64'(want.syns));
            check_field("fin_total", 64'(got.fins), 64'(want.fins));
            check_field("rst_total", 64'(got.rsts), 64'(want.rsts));
            checked++;
        endtask

        function int outstanding();
            return owed_records.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        pkt_valid;
    logic        pkt_stall;
    logic [31:0] src_address;
    logic [31:0] dst_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [7:0]  protocol;
    logic [31:0] ts_seconds;
    logic [19:0] ts_microseconds;
    logic [17:0] cap_length;
    logic [17:0] wire_length;
    logic [7:0]  flag_byte;
    logic        rec_valid;
    logic        rec_stall;
    logic [1:0]  direction_slot;
    logic [31:0] packet_total;
    logic [47:0] byte_total;
    logic [47:0] captured_byte_total;
    logic [51:0] first_time_us;
    logic [51:0] last_time_us;
    logic [31:0] truncated_total;
    logic [17:0] max_wire_length;
    logic [17:0] max_capture_length;
    logic [31:0] syn_total;
    logic [31:0] fin_total;
    logic [31:0] rst_total;

    flow_record_scoreboard sb;
    flow_key_t   key_a;
    flow_key_t   key_b;
    flow_key_t   key_c;
    logic [31:0] base_secs;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_left;
    int          stall_cycles;
    int          quiet_cycles;

    bidirectional_flow_stats_update u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .pkt_valid           (pkt_valid),
        .pkt_stall           (pkt_stall),
        .src_address         (src_address),
        .dst_address         (dst_address),
        .source_port         (source_port),
        .dest_port           (dest_port),
        .protocol            (protocol),
        .ts_seconds          (ts_seconds),
        .ts_microseconds     (ts_microseconds),
        .cap_length          (cap_length),
        .wire_length         (wire_length),
        .flag_byte           (flag_byte),
        .rec_valid           (rec_valid),
        .rec_stall           (rec_stall),
        .direction_slot      (direction_slot),
        .packet_total        (packet_total),
        .byte_total          (byte_total),
        .captured_byte_total (captured_byte_total),
        .first_time_us       (first_time_us),
        .last_time_us        (last_time_us),
        .truncated_total     (truncated_total),
        .max_wire_length     (max_wire_length),
        .max_capture_length  (max_capture_length),
        .syn_total           (syn_total),
        .fin_total           (fin_total),
        .rst_total           (rst_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic flow_key_t random_key();
        flow_key_t k;
        k.src_address = $urandom;
        k.dst_address = $urandom;
        k.source_port = 16'($urandom);
        k.dest_port   = 16'($urandom);
        k.protocol    = $urandom_range(0, 1) ? PROTO_TCP : 8'($urandom);
        return k;
    endfunction

    function automatic packet_beat_t make_packet(input flow_key_t k, input logic [31:0] secs,
                                                 input logic [19:0] usecs,
                                                 input logic [17:0] cap_len,
                                                 input logic [17:0] wire_len,
                                                 input logic [7:0] flags);
        packet_beat_t p;
        p.key      = k;
        p.secs     = secs;
        p.usecs    = usecs;
        p.cap_len  = cap_len;
        p.wire_len = wire_len;
        p.flags    = flags;
        return p;
    endfunction

    // Mostly traffic of the two directions, some stray keys and near misses
    function automatic packet_beat_t random_packet();
        packet_beat_t p;
        int           pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
            p.key = key_a;
        else if (pick < 80)
            p.key = key_b;
        else if (pick < 90)
            p.key = random_key();
        else
            p.key = ($urandom_range(0, 1) ? key_a : key_b) ^ (104'd1 << $urandom_range(0, 103));

        // a few wild timestamps, the rest near the session time
        pick = $urandom_range(0, 99);
        if (pick < 3)
        begin
            p.secs  = $urandom;
            p.usecs = 20'($urandom);
        end
        else
        begin
            p.secs  = base_secs + $urandom_range(0, 600) - 300;
            p.usecs = 20'($urandom_range(0, 999999));
        end

        pick = $urandom_range(0, 99);
        p.wire_len = 18'($urandom_range(40, 1514));
        if (pick < 5)
        begin
            p.wire_len = 18'($urandom);
            p.cap_len  = 18'($urandom);
        end
        else if (pick < 45)
            p.cap_len = 18'($urandom_range(0, p.wire_len));
        else if (pick < 55)
            p.cap_len = p.wire_len + 18'($urandom_range(1, 64));
        else
            p.cap_len = p.wire_len;
        p.flags = 8'($urandom);
        return p;
    endfunction

    // Offer one packet beat from a falling edge and hold it until taken
    task automatic send_packet(input packet_beat_t p);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pkt_valid <= 1'b0;
            @(negedge clk);
        end
        pkt_valid       <= 1'b1;
        src_address     <= p.key.src_address;
        dst_address     <= p.key.dst_address;
        source_port     <= p.key.source_port;
        dest_port       <= p.key.dest_port;
        protocol        <= p.key.protocol;
        ts_seconds      <= p.secs;
        ts_microseconds <= p.usecs;
        cap_length      <= p.cap_len;
        wire_length     <= p.wire_len;
        flag_byte       <= p.flags;
        @(posedge clk);
        while (pkt_stall)
        begin
            stall_cycles++;
            @(posedge clk);
        end
        sb.note_packet(p);
        @(negedge clk);
    endtask

    // Stop offering until every record owed has come back
    task automatic wait_for_records();
        pkt_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Record side: random or forced stall, changed at the falling edge
    initial
    begin
        rec_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                rec_stall <= 1'b1;
                hold_left--;
            end
            else
                rec_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Take record beats at the rising edge
    always @(posedge clk)
    begin : take_record
        flow_record_t seen;
        if (rst_n === 1'b1 && rec_valid === 1'b1 && rec_stall === 1'b0)
        begin
            seen.slot      = slot_t'(direction_slot);
            seen.packets   = packet_total;
            seen.bytes     = byte_total;
            seen.cap_bytes = captured_byte_total;
            seen.first_us  = first_time_us;
            seen.last_us   = last_time_us;
            seen.truncated = truncated_total;
            seen.wire_peak = max_wire_length;
            seen.cap_peak  = max_capture_length;
            seen.syns      = syn_total;
            seen.fins      = fin_total;
            seen.rsts      = rst_total;
            sb.check_record(seen);
        end
    end

    // Watchdog: too long without any beat on either side ends the run
    always @(posedge clk)
    begin
        if (rst_n !== 1'b1 || (pkt_valid && !pkt_stall) || (rec_valid && !rec_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", quiet_cycles);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        flow_key_t k;
        rst_n           = 1'b0;
        pkt_valid       = 1'b0;
        src_address     = '0;
        dst_address     = '0;
        source_port     = '0;
        dest_port       = '0;
        protocol        = '0;
        ts_seconds      = '0;
        ts_microseconds = '0;
        cap_length      = '0;
        wire_length     = '0;
        flag_byte       = '0;
        hold_left       = 0;
        stall_cycles    = 0;
        quiet_cycles    = 0;
        send_idle_pct   = 12;
        recv_idle_pct   = 87;
        sb              = new();

        // the connection: A one way, B the reverse, C a stray key
        key_a             = random_key();
        key_a.protocol    = PROTO_TCP;
        key_b.src_address = key_a.dst_address;
        key_b.dst_address = key_a.src_address;
        key_b.source_port = key_a.dest_port;
        key_b.dest_port   = key_a.source_port;
        key_b.protocol    = PROTO_TCP;
        key_c             = random_key();
        key_c.protocol    = PROTO_TCP;
        base_secs         = $urandom_range(1000, 32'h7FFF_0000);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: first packet, window moves, flags, truncation, stray keys
        send_packet(make_packet(key_a, base_secs, 20'd500000, 18'd60, 18'd60, 8'h02));
        send_packet(make_packet(key_b, base_secs, 20'd700000, 18'd1400, 18'd1500, 8'h12));
        send_packet(make_packet(key_a, base_secs - 1, 20'd999999, 18'd1500, 18'd1500, 8'h10));
        send_packet(make_packet(key_a, base_secs + 1, 20'd1000000, 18'd100, 18'd80, 8'h01));
        send_packet(make_packet(key_b, base_secs + 2, 20'd0, 18'd64, 18'd64, 8'h04));
        send_packet(make_packet(key_c, base_secs, 20'd1, 18'd40, 18'd900, 8'hFF));
        k          = key_a;
        k.protocol = 8'd17;
        send_packet(make_packet(k, base_secs, 20'd2, 18'd200, 18'd200, 8'hFF));
        send_packet(make_packet('0, base_secs, 20'd3, 18'd10, 18'd20, 8'h07));
        send_packet(make_packet('1, base_secs, 20'd4, 18'd30, 18'd30, 8'hF8));
        send_packet(make_packet(key_a, base_secs + 3, 20'd5, 18'd70, 18'd70, 8'h00));
        send_packet(make_packet(key_b, base_secs + 3, 20'd6, 18'd70, 18'd71, 8'h07));
        k           = key_b;
        k.dest_port = k.dest_port ^ 16'h8000;
        send_packet(make_packet(k, base_secs, 20'd7, 18'd90, 18'd90, 8'h02));
        send_packet(make_packet(key_a, base_secs, 20'd8, 18'd90, 18'd90, 8'hF8));

        // random traffic, busy sender and slow receiver
        repeat (300) send_packet(random_packet());
        wait_for_records();

        // slow sender and busy receiver
        send_idle_pct = 87;
        recv_idle_pct = 12;
        repeat (310) send_packet(random_packet());
        wait_for_records();

        // no idling, with one long receiver hold-off to back the block up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (150) send_packet(random_packet());
        hold_left = HOLD_CYCLES;
        repeat (180) send_packet(random_packet());
        wait_for_records();

        // time and length extremes last, since they pin the window and the peaks
        send_packet(make_packet(key_a, 32'd0, 20'd0, 18'h3FFFF, 18'd0, 8'h02));
        send_packet(make_packet(key_b, 32'hFFFF_FFFF, 20'hFFFFF, 18'd0, 18'h3FFFF, 8'h01));
        send_packet(make_packet(key_c, 32'hFFFF_FFFF, 20'd999999, 18'h3FFFF, 18'h3FFFF,
                                8'h04));
        wait_for_records();
        repeat (8) @(posedge clk);

        if (sb.outstanding() != 0)
            sb.report_mismatch($sformatf("%0d records never arrived", sb.outstanding()));
        $display("Covered %0d packets: %0d on direction A, %0d on B, %0d with stray keys.",
                 sb.checked, sb.slot_hits[0], sb.slot_hits[1], sb.slot_hits[2]);
        $display("Input held off for %0d cycles by back-pressure; %0d mismatches.",
                 stall_cycles, sb.errors);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
